@@ rtl/cffe_pkg.sv @@
package cffe_pkg;

  // Coordinate width after clipping; frame sides go up to 8191
  localparam int COORD_W = 13;

  localparam logic [2:0] CMD_INIT    = 3'd0;
  localparam logic [2:0] CMD_CLEAR   = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_READ    = 3'd3;
  localparam logic [2:0] CMD_FILL    = 3'd4;
  localparam logic [2:0] CMD_OUTLINE = 3'd5;

  // Rectangle as handed to the clip unit
  typedef struct packed {
    logic signed [17:0] rx;
    logic signed [17:0] ry;
    logic signed [15:0] rw;
    logic signed [15:0] rh;
  } rect_t;

  // Clipped span: columns [x0, x1), rows [y0, y1)
  typedef struct packed {
    logic               nonempty;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
  } clip_t;

endpackage

@@ rtl/cffe_clip.sv @@
module cffe_clip import cffe_pkg::*; #(
  parameter int FRAME_COLUMNS = 320,
  parameter int FRAME_ROWS    = 200
) (
  input  rect_t rect,
  output clip_t res
);

  localparam logic signed [18:0] COLS_S = 19'(FRAME_COLUMNS);
  localparam logic signed [18:0] ROWS_S = 19'(FRAME_ROWS);

  logic signed [18:0] rx_w, ry_w, rw_w, rh_w;
  logic signed [18:0] sx1, sy1, x0_w, y0_w, x1_w, y1_w;

  assign rx_w = {rect.rx[17], rect.rx};
  assign ry_w = {rect.ry[17], rect.ry};
  assign rw_w = {{3{rect.rw[15]}}, rect.rw};
  assign rh_w = {{3{rect.rh[15]}}, rect.rh};

  assign sx1 = rx_w + rw_w;
  assign sy1 = ry_w + rh_w;

  assign x0_w = (rx_w < 19'sd0) ? 19'sd0 : rx_w;
  assign y0_w = (ry_w < 19'sd0) ? 19'sd0 : ry_w;
  assign x1_w = (sx1 > COLS_S) ? COLS_S : sx1;
  assign y1_w = (sy1 > ROWS_S) ? ROWS_S : sy1;

  assign res.nonempty = (rect.rw > 16'sd0) && (rect.rh > 16'sd0) &&
                        (x0_w < x1_w) && (y0_w < y1_w);
  // Only meaningful when nonempty, then all values lie within the frame
  assign res.x0 = x0_w[COORD_W-1:0];
  assign res.x1 = x1_w[COORD_W-1:0];
  assign res.y0 = y0_w[COORD_W-1:0];
  assign res.y1 = y1_w[COORD_W-1:0];

endmodule

@@ rtl/cffe_mem.sv @@
module cffe_mem #(
  parameter int DEPTH = 64000,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic          rd_en,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wr_data,
  output logic [7:0]    rd_data
);

  logic [7:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[addr];
    end
  end

endmodule

@@ rtl/clipped_framebuffer_fill_engine_core.sv @@
// Channel  Dir  Ports                  Beat contents (low bit up)
// in       in   in_tvalid/tready       tdata: x_pos[15:0] y_pos[31:16] rect_width[47:32]
//                                      rect_height[63:48] color[71:64]; tuser: command
// out      out  out_tvalid/tready      tdata: pixel_value[7:0] took_effect[8], rest 0
//
// One command at a time: accept, then per rectangle pass a clip step and an
// address setup step, then the walk over its pixels, then a step that
// loads the output register. A pass whose clipped span is empty ends at its
// clip step. Init and clear walk the whole frame, a read adds a step for the
// registered memory read, and an outline with positive extents runs four passes.
// The single frame memory port sets the one-pixel-per-cycle walk rate.
// Synchronous active-low reset clears the sequencer, output valid and active
// flag; the frame memory is not cleared. A stalled output holds its beat and
// a new command is still taken while it waits.
module clipped_framebuffer_fill_engine_core import cffe_pkg::*; #(
  parameter int FRAME_COLUMNS = 320,
  parameter int FRAME_ROWS    = 200
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // x_pos, y_pos, rect_width, rect_height, color
  input  logic [2:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // pixel_value, took_effect, zero fill
);

  localparam int DEPTH = FRAME_COLUMNS * FRAME_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] COLS_A = AW'(FRAME_COLUMNS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CLIP = 6'b000010,
    S_BASE = 6'b000100,
    S_WALK = 6'b001000,
    S_READ = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]         cmd_r;
  logic signed [15:0] x_r, y_r, w_r, h_r;
  logic [7:0]         color_r;
  logic [1:0]         pass_r, pass_nxt;
  logic               took_r, took_nxt;
  logic               active_r, active_nxt;
  logic [7:0]         pix_r, pix_nxt;
  clip_t              clip_r, clip_nxt;
  logic [COORD_W-1:0] xx_r, xx_nxt, yy_r, yy_nxt;
  logic [AW-1:0]      addr_r, addr_nxt, row_r, row_nxt;
  logic               out_valid_r;
  logic [7:0]         out_pix_r;
  logic               out_took_r;

  rect_t              rect;
  clip_t              clip_res;
  logic [AW-1:0]      base_addr;
  logic               in_acc, wr_en, rd_en, row_end, last_row, is_read;
  logic [7:0]         mem_rd, wr_data;
  logic signed [17:0] x_s, y_s, w_s, h_s;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign x_s = {{2{x_r[15]}}, x_r};
  assign y_s = {{2{y_r[15]}}, y_r};
  assign w_s = {{2{w_r[15]}}, w_r};
  assign h_s = {{2{h_r[15]}}, h_r};

  // Rectangle for the current pass
  always_comb begin
    rect.rx = x_s;
    rect.ry = y_s;
    rect.rw = w_r;
    rect.rh = h_r;
    case (cmd_r)
      CMD_INIT, CMD_CLEAR: begin
        rect.rx = '0;
        rect.ry = '0;
        rect.rw = 16'(FRAME_COLUMNS);
        rect.rh = 16'(FRAME_ROWS);
      end
      CMD_WRITE, CMD_READ: begin
        rect.rw = 16'sd1;
        rect.rh = 16'sd1;
      end
      CMD_OUTLINE: begin
        case (pass_r)
          2'd0: rect.rh = 16'sd1;
          2'd1: begin
            rect.ry = y_s + h_s - 18'sd1;
            rect.rh = 16'sd1;
          end
          2'd2: rect.rw = 16'sd1;
          default: begin
            rect.rx = x_s + w_s - 18'sd1;
            rect.rw = 16'sd1;
          end
        endcase
      end
      default: ;
    endcase
  end

  cffe_clip #(
    .FRAME_COLUMNS(FRAME_COLUMNS),
    .FRAME_ROWS   (FRAME_ROWS)
  ) u_clip (
    .rect(rect),
    .res (clip_res)
  );

  assign base_addr = AW'(clip_r.y0) * COLS_A + AW'(clip_r.x0);
  assign is_read   = (cmd_r == CMD_READ);
  assign row_end   = ((xx_r + 1'b1) == clip_r.x1);
  assign last_row  = ((yy_r + 1'b1) == clip_r.y1);
  assign wr_en     = (state_r == S_WALK) && !is_read;
  assign rd_en     = (state_r == S_WALK) && is_read;
  assign wr_data   = (cmd_r == CMD_INIT) ? 8'd0 : color_r;

  cffe_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .rd_en  (rd_en),
    .addr   (addr_r),
    .wr_data(wr_data),
    .rd_data(mem_rd)
  );

  always_comb begin
    state_nxt  = state_r;
    pass_nxt   = pass_r;
    took_nxt   = took_r;
    active_nxt = active_r;
    pix_nxt    = pix_r;
    clip_nxt   = clip_r;
    xx_nxt     = xx_r;
    yy_nxt     = yy_r;
    addr_nxt   = addr_r;
    row_nxt    = row_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pass_nxt = 2'd0;
          took_nxt = 1'b0;
          pix_nxt  = 8'd0;
          if (in_tuser == CMD_INIT) begin
            active_nxt = 1'b1;
          end
          if (in_tuser inside {CMD_INIT, CMD_CLEAR, CMD_WRITE, CMD_READ, CMD_FILL}) begin
            state_nxt = S_CLIP;
          end else if ((in_tuser == CMD_OUTLINE) &&
                       ($signed(in_tdata[47:32]) > 16'sd0) &&
                       ($signed(in_tdata[63:48]) > 16'sd0)) begin
            state_nxt = S_CLIP;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_CLIP: begin
        clip_nxt = clip_res;
        if (clip_res.nonempty && active_r) begin
          took_nxt  = 1'b1;
          state_nxt = S_BASE;
        end else if ((cmd_r == CMD_OUTLINE) && (pass_r != 2'd3)) begin
          pass_nxt = pass_r + 2'd1;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_BASE: begin
        addr_nxt  = base_addr;
        row_nxt   = base_addr;
        xx_nxt    = clip_r.x0;
        yy_nxt    = clip_r.y0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (is_read) begin
          state_nxt = S_READ;
        end else if (!row_end) begin
          xx_nxt   = xx_r + 1'b1;
          addr_nxt = addr_r + 1'b1;
        end else if (!last_row) begin
          xx_nxt   = clip_r.x0;
          yy_nxt   = yy_r + 1'b1;
          row_nxt  = row_r + COLS_A;
          addr_nxt = row_r + COLS_A;
        end else if ((cmd_r == CMD_OUTLINE) && (pass_r != 2'd3)) begin
          pass_nxt  = pass_r + 2'd1;
          state_nxt = S_CLIP;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_READ: begin
        pix_nxt   = mem_rd;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      if ((state_r == S_RESP) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_tuser;
      x_r     <= in_tdata[15:0];
      y_r     <= in_tdata[31:16];
      w_r     <= in_tdata[47:32];
      h_r     <= in_tdata[63:48];
      color_r <= in_tdata[71:64];
    end
    pass_r <= pass_nxt;
    took_r <= took_nxt;
    pix_r  <= pix_nxt;
    clip_r <= clip_nxt;
    xx_r   <= xx_nxt;
    yy_r   <= yy_nxt;
    addr_r <= addr_nxt;
    row_r  <= row_nxt;
    if ((state_r == S_RESP) && (!out_valid_r || out_tready)) begin
      out_pix_r  <= pix_r;
      out_took_r <= took_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_took_r, out_pix_r};

  // Drawing never touches the store while inactive
  a_write_active: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en || rd_en) |-> active_r)
    else $error("frame store accessed while inactive");

  a_walk_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> ((xx_r < clip_r.x1) && (yy_r < clip_r.y1) &&
                             (xx_r >= clip_r.x0) && (yy_r >= clip_r.y0)))
    else $error("walk counter left the clipped span");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (32'(addr_r) < 32'(DEPTH)))
    else $error("frame address beyond store depth");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_RESP))
    else $error("output beat raised outside response step");

endmodule

@@ tb/tb_clipped_framebuffer_fill_engine_core.sv @@
module tb_clipped_framebuffer_fill_engine_core;
  import cffe_pkg::*;

  localparam int COLS = 320;
  localparam int ROWS = 200;

  // Codes the block must ignore
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int WATCHDOG_LIMIT  = 250000;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int HEAVY_BUDGET    = 5;
  localparam int PHASE_ITEMS     = 185;

  typedef struct {
    logic [2:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [7:0]         color;
  } draw_cmd_t;

  typedef struct {
    logic [7:0] pixel;
    logic       hit;
  } draw_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;   // x_pos, y_pos, rect_width, rect_height, color
  logic [2:0]  in_tuser = '0;   // command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // pixel_value, took_effect, zero fill

  always #10 clk = ~clk;

  clipped_framebuffer_fill_engine_core #(
    .FRAME_COLUMNS(COLS),
    .FRAME_ROWS   (ROWS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Shadow of the frame store and the active flag
  logic [7:0]   frame_px [COLS*ROWS];
  bit           panel_on;

  draw_cmd_t    cmd_queue[$];
  draw_result_t pixel_results[$];
  draw_cmd_t    beat_on_bus;

  int err_count;
  int sender_idle_pct;
  int recv_stall_pct;
  int hold_token;
  int hold_seen;
  int hold_left;
  int quiet_cycles;
  int heavy_left;

  function automatic bit on_frame(int x, int y);
    return x >= 0 && x < COLS && y >= 0 && y < ROWS;
  endfunction

  function automatic bit fill_span(int x, int y, int w, int h, logic [7:0] c);
    int x0, y0, x1, y1;
    if (!panel_on || w <= 0 || h <= 0) return 1'b0;
    x0 = x < 0 ? 0 : x;
    y0 = y < 0 ? 0 : y;
    x1 = x + w > COLS ? COLS : x + w;
    y1 = y + h > ROWS ? ROWS : y + h;
    if (x0 >= x1 || y0 >= y1) return 1'b0;
    for (int yy = y0; yy < y1; yy++)
      for (int xx = x0; xx < x1; xx++)
        frame_px[yy*COLS + xx] = c;
    return 1'b1;
  endfunction

  function automatic draw_result_t paint(draw_cmd_t d);
    draw_result_t r;
    int x, y, w, h;
    bit top, bottom, left, right;
    x = int'(d.x);
    y = int'(d.y);
    w = int'(d.w);
    h = int'(d.h);
    r.pixel = '0;
    r.hit   = 1'b0;
    case (d.op)
      CMD_INIT: begin
        foreach (frame_px[i]) frame_px[i] = '0;
        panel_on = 1'b1;
        r.hit = 1'b1;
      end
      CMD_CLEAR: begin
        if (panel_on) begin
          foreach (frame_px[i]) frame_px[i] = d.color;
          r.hit = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (panel_on && on_frame(x, y)) begin
          frame_px[y*COLS + x] = d.color;
          r.hit = 1'b1;
        end
      end
      CMD_READ: begin
        if (panel_on && on_frame(x, y)) begin
          r.pixel = frame_px[y*COLS + x];
          r.hit = 1'b1;
        end
      end
      CMD_FILL: r.hit = fill_span(x, y, w, h, d.color);
      CMD_OUTLINE: begin
        if (w > 0 && h > 0) begin
          top    = fill_span(x, y, w, 1, d.color);
          bottom = fill_span(x, y + h - 1, w, 1, d.color);
          left   = fill_span(x, y, 1, h, d.color);
          right  = fill_span(x + w - 1, y, 1, h, d.color);
          r.hit = top | bottom | left | right;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] pick_coord(int lim);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = int'($urandom_range(0, 48)) - 8;
      5, 6, 7:       v = int'($urandom_range(0, lim + 40)) - 20;
      8:             v = lim - 30 + int'($urandom_range(0, 38));
      default:       v = int'($urandom);
    endcase
    return v[15:0];
  endfunction

  // Mostly small extents; a wide one spans the whole 16-bit range
  function automatic logic signed [15:0] pick_extent(bit wide);
    int v;
    case ($urandom_range(0, 19))
      0:       v = 0;
      1:       v = -int'($urandom_range(1, 300));
      default: v = wide ? int'($urandom) : int'($urandom_range(1, 12));
    endcase
    return v[15:0];
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t d;
    int r;
    int shape;
    r = $urandom_range(0, 99);
    d.x = pick_coord(COLS);
    d.y = pick_coord(ROWS);
    d.color = 8'($urandom_range(0, 255));
    shape = $urandom_range(0, 9);
    d.w = pick_extent(shape == 0);
    d.h = pick_extent(shape == 1);
    if (r < 25) d.op = CMD_WRITE;
    else if (r < 55) d.op = CMD_READ;
    else if (r < 75) d.op = CMD_FILL;
    else if (r < 90) begin
      // edges are one pixel thick, so both extents may be wide
      d.op = CMD_OUTLINE;
      d.w = pick_extent($urandom_range(0, 9) < 3);
      d.h = pick_extent($urandom_range(0, 9) < 3);
    end else if (r < 93) d.op = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    else if (r < 95 && heavy_left > 0) begin
      heavy_left--;
      d.op = $urandom_range(0, 1) ? CMD_CLEAR : CMD_INIT;
    end else d.op = CMD_READ;
    return d;
  endfunction

  task automatic queue_cmd(logic [2:0] op, int x, int y, int w, int h, int c);
    draw_cmd_t d;
    d.op = op;
    d.x = x[15:0];
    d.y = y[15:0];
    d.w = w[15:0];
    d.h = h[15:0];
    d.color = c[7:0];
    cmd_queue.push_back(d);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch: %s got %0h expected %0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic drain_all();
    while (cmd_queue.size() != 0 || in_tvalid || pixel_results.size() != 0)
      @(negedge clk);
  endtask

  // Driver: predict on acceptance, then offer the next pending command
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) pixel_results.push_back(paint(beat_on_bus));
      if (!in_tvalid || in_tready) begin
        if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          beat_on_bus = cmd_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= beat_on_bus.op;
          in_tdata  <= {beat_on_bus.color, beat_on_bus.h, beat_on_bus.w,
                        beat_on_bus.y, beat_on_bus.x};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_OFF_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  // Monitor
  always @(posedge clk) begin : result_check
    draw_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", int'(out_tdata), 0);
      end else begin
        want = pixel_results.pop_front();
        if (out_tdata[7:0] !== want.pixel)
          report_mismatch("pixel_value", int'(out_tdata[7:0]), int'(want.pixel));
        if (out_tdata[8] !== want.hit)
          report_mismatch("took_effect", int'(out_tdata[8]), int'(want.hit));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_clipped_framebuffer_fill_engine_core: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_token      = 0;
    heavy_left      = HEAVY_BUDGET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Inactive block: everything but init is dropped
    queue_cmd(CMD_READ, 10, 10, 0, 0, 0);
    queue_cmd(CMD_WRITE, 5, 5, 0, 0, 'hAA);
    queue_cmd(CMD_FILL, 0, 0, 4, 4, 'h12);
    queue_cmd(CMD_CLEAR, 0, 0, 0, 0, 'h34);
    queue_cmd(CMD_SPARE_LO, 1, 1, 1, 1, 'hFF);
    queue_cmd(CMD_INIT, 0, 0, 0, 0, 0);
    queue_cmd(CMD_READ, 0, 0, 0, 0, 0);
    // Corners and just off the frame
    queue_cmd(CMD_WRITE, 0, 0, 0, 0, 'hFF);
    queue_cmd(CMD_WRITE, COLS - 1, ROWS - 1, 0, 0, 'h5A);
    queue_cmd(CMD_WRITE, COLS, 0, 0, 0, 'h01);
    queue_cmd(CMD_WRITE, -1, 0, 0, 0, 'h02);
    queue_cmd(CMD_READ, 0, 0, 0, 0, 0);
    queue_cmd(CMD_READ, COLS - 1, ROWS - 1, 0, 0, 0);
    queue_cmd(CMD_READ, 0, ROWS, 0, 0, 0);
    queue_cmd(CMD_READ, -32768, 32767, 0, 0, 0);
    // Fills: extreme coordinates, corner clip, empty sizes, off-frame, whole frame
    queue_cmd(CMD_FILL, -32768, -32768, 32767, 32767, 'h11);
    queue_cmd(CMD_FILL, 32767, 0, 1, 1, 'h22);
    queue_cmd(CMD_FILL, -5, -5, 12, 9, 'h33);
    queue_cmd(CMD_FILL, 3, 3, 0, 5, 'h55);
    queue_cmd(CMD_FILL, 3, 3, 5, -1, 'h55);
    queue_cmd(CMD_FILL, COLS, 0, 10, 10, 'h56);
    queue_cmd(CMD_FILL, 0, 0, 32767, 32767, 'h44);
    // Outlines: all edges just outside, single pixel, ordinary
    queue_cmd(CMD_OUTLINE, -1, -1, COLS + 2, ROWS + 2, 'h65);
    queue_cmd(CMD_OUTLINE, 10, 10, 1, 1, 'h66);
    queue_cmd(CMD_OUTLINE, 2, 3, 20, 10, 'h77);
    queue_cmd(CMD_READ, 2, 3, 0, 0, 0);
    queue_cmd(CMD_READ, 5, 5, 0, 0, 0);
    queue_cmd(CMD_SPARE_HI, 0, 0, 0, 0, 0);
    queue_cmd(CMD_CLEAR, 0, 0, 0, 0, 'h99);
    queue_cmd(CMD_READ, 100, 100, 0, 0, 0);
    drain_all();

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = (ph == 1) ? 55 : (ph == 3) ? 14 : 0;
      recv_stall_pct  = (ph == 2) ? 55 : (ph == 3) ? 14 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) cmd_queue.push_back(random_cmd());
      if (ph == 0) begin
        // back up the output while commands keep coming
        repeat (30) @(negedge clk);
        hold_token++;
      end
      drain_all();
    end

    repeat (20) @(negedge clk);
    if (err_count == 0)
      $display("tb_clipped_framebuffer_fill_engine_core: done, clean");
    else
      $display("tb_clipped_framebuffer_fill_engine_core: done, errors");
    $finish;
  end

endmodule
